[design/gpl_pkg.sv]
// Shared types and constants for the glyph pen layout block.
package gpl_pkg;

    localparam int TABLE_ENTRIES_DEF = 256;

    localparam int CODE_W   = 8;
    localparam int METRIC_W = 16;
    localparam int SIZE_W   = 15;
    localparam int PEN_W    = 18;
    localparam int OUT_W    = 24;
    localparam int LH_W     = 16;

    localparam logic [LH_W-1:0]   LINE_HEIGHT_RST = 16'd1024;
    localparam logic [CODE_W-1:0] NEWLINE_CODE    = 8'd10;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_PLACE = 1'b1;

    // One character's metrics, all in 1/64 pixel.
    typedef struct packed {
        logic signed [METRIC_W-1:0] advance;
        logic signed [METRIC_W-1:0] bearing_x;
        logic signed [METRIC_W-1:0] bearing_y;
        logic        [SIZE_W-1:0]   width;
        logic        [SIZE_W-1:0]   height;
    } gpl_metrics_t;

    // Running bounding box, 1/64 pixel.
    typedef struct packed {
        logic signed [OUT_W-1:0] min_x;
        logic signed [OUT_W-1:0] max_x;
        logic signed [OUT_W-1:0] min_y;
        logic signed [OUT_W-1:0] max_y;
    } gpl_box_t;

endpackage

[design/gpl_metric_table.sv]
// Character metrics memory with per-entry valid bits and a registered read.
module gpl_metric_table
    import gpl_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic              rd_en,
    input  logic [CODE_W-1:0] code,
    input  gpl_metrics_t      wr_data,
    output gpl_metrics_t      rd_data
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    gpl_metrics_t             mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_reg;
    gpl_metrics_t             rd_data_reg;
    logic                     rd_hit_reg;
    logic                     hit;
    logic [IDX_W-1:0]         idx;

    // Codes at or past the table size never hit and read as zero metrics.
    assign hit = {1'b0, code} < (CODE_W + 1)'(TABLE_ENTRIES);
    assign idx = code[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en && hit)
        begin
            mem[idx] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (wr_en && hit)
            begin
                valid_reg[idx] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_hit_reg <= hit && valid_reg[idx];
            end
        end
    end

    assign rd_data = rd_hit_reg ? rd_data_reg : '0;

endmodule

[design/gpl_place_calc.sv]
// Glyph origin, bounding box and pen update for one placed character.
module gpl_place_calc
    import gpl_pkg::*;
(
    input  logic signed [PEN_W-1:0] pen_x,
    input  logic signed [PEN_W-1:0] pen_y,
    input  logic                    box_valid,
    input  gpl_box_t                box,
    input  gpl_metrics_t            metrics,
    input  logic                    first,
    input  logic                    newline,
    input  logic [LH_W-1:0]         line_height,
    output logic signed [OUT_W-1:0] pos_x,
    output logic signed [OUT_W-1:0] pos_y,
    output gpl_box_t                box_next,
    output logic signed [PEN_W-1:0] pen_x_next,
    output logic signed [PEN_W-1:0] pen_y_next
);

    function automatic logic [OUT_W-1:0] sat_out(input logic [OUT_W:0] v);
        logic [OUT_W-1:0] r;
        if (v[OUT_W] != v[OUT_W-1])
            r = v[OUT_W] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
        else
            r = v[OUT_W-1:0];
        return r;
    endfunction

    function automatic logic [PEN_W-1:0] sat_pen(input logic [PEN_W:0] v);
        logic [PEN_W-1:0] r;
        if (v[PEN_W] != v[PEN_W-1])
            r = v[PEN_W] ? {1'b1, {(PEN_W-1){1'b0}}} : {1'b0, {(PEN_W-1){1'b1}}};
        else
            r = v[PEN_W-1:0];
        return r;
    endfunction

    logic [PEN_W-1:0]        pen_x_base;
    logic [PEN_W-1:0]        pen_y_base;
    logic [PEN_W-1:0]        pen_x_mid;
    logic [OUT_W:0]          ox_wide;
    logic [OUT_W:0]          oy_wide;
    logic [OUT_W:0]          hx_wide;
    logic [OUT_W:0]          hy_wide;
    logic signed [OUT_W-1:0] hx;
    logic signed [OUT_W-1:0] hy;
    logic [9:0]              adv_px;
    logic [PEN_W:0]          pen_x_wide;
    logic [PEN_W:0]          pen_y_wide;
    logic                    box_live;

    always_comb
    begin
        // A new string starts from a cleared pen and an empty box.
        pen_x_base = first ? '0 : pen_x;
        pen_y_base = first ? '0 : pen_y;
        box_live   = box_valid && !first;

        ox_wide = {pen_x_base[PEN_W-1], pen_x_base, 6'd0}
                + {{(OUT_W+1-METRIC_W){metrics.bearing_x[METRIC_W-1]}}, metrics.bearing_x};
        oy_wide = {pen_y_base[PEN_W-1], pen_y_base, 6'd0}
                - {{(OUT_W+1-METRIC_W){metrics.bearing_y[METRIC_W-1]}}, metrics.bearing_y};
        pos_x = sat_out(ox_wide);
        pos_y = sat_out(oy_wide);

        // The glyph extent uses its size floored to whole pixels.
        hx_wide = {pos_x[OUT_W-1], pos_x} + {10'd0, metrics.width[SIZE_W-1:6], 6'd0};
        hy_wide = {pos_y[OUT_W-1], pos_y} + {10'd0, metrics.height[SIZE_W-1:6], 6'd0};
        hx = sat_out(hx_wide);
        hy = sat_out(hy_wide);

        if (!box_live)
        begin
            box_next.min_x = pos_x;
            box_next.max_x = hx;
            box_next.min_y = pos_y;
            box_next.max_y = hy;
        end
        else
        begin
            box_next.min_x = (pos_x < box.min_x) ? pos_x : box.min_x;
            box_next.max_x = (hx > box.max_x) ? hx : box.max_x;
            box_next.min_y = (pos_y < box.min_y) ? pos_y : box.min_y;
            box_next.max_y = (hy > box.max_y) ? hy : box.max_y;
        end

        // A newline returns the pen to the left edge and drops one line.
        pen_y_wide = {pen_y_base[PEN_W-1], pen_y_base} + {9'd0, line_height[LH_W-1:6]};
        pen_x_mid  = newline ? '0 : pen_x_base;
        pen_y_next = newline ? sat_pen(pen_y_wide) : pen_y_base;

        // Advance in whole pixels, truncated toward zero.
        adv_px = metrics.advance[METRIC_W-1:6]
               + {9'd0, metrics.advance[METRIC_W-1] & (|metrics.advance[5:0])};
        pen_x_wide = {pen_x_mid[PEN_W-1], pen_x_mid} + {{9{adv_px[9]}}, adv_px};
        pen_x_next = sat_pen(pen_x_wide);
    end

endmodule

[design/glyph_pen_layout_with_bounds.sv]
// Top level of the glyph pen layout block with running bounding box.
// A place word reads its metrics from the table into the lookup stage when accepted; its
// result is registered when the lookup stage moves on, which out_stall can hold off.
// Throughput: one word per cycle unless in_stall; load words write the table, no result.
// Reset clears pen, box, the line height (to 1024) and the valid bit of every table
// entry at once, so unwritten entries read as zero metrics; no clearing pass is needed.
module glyph_pen_layout_with_bounds
    import gpl_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       cfg_write,
    input  logic [LH_W-1:0]            cfg_data,

    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       req_type,
    input  logic [CODE_W-1:0]          char_code,
    input  logic                       first_of_string,
    input  logic signed [METRIC_W-1:0] advance_in,
    input  logic signed [METRIC_W-1:0] bearing_x_in,
    input  logic signed [METRIC_W-1:0] bearing_y_in,
    input  logic [SIZE_W-1:0]          glyph_width_in,
    input  logic [SIZE_W-1:0]          glyph_height_in,

    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [OUT_W-1:0]    pos_x,
    output logic signed [OUT_W-1:0]    pos_y,
    output logic signed [OUT_W-1:0]    box_min_x,
    output logic signed [OUT_W-1:0]    box_max_x,
    output logic signed [OUT_W-1:0]    box_min_y,
    output logic signed [OUT_W-1:0]    box_max_y
);

    logic [LH_W-1:0]         line_height_reg;

    // The lookup stage holds a place word while its metrics come out of the table.
    logic                    s1_valid_reg;
    logic                    s1_first_reg;
    logic                    s1_newline_reg;

    // Layout state carried from one place word to the next.
    logic signed [PEN_W-1:0] pen_x_reg;
    logic signed [PEN_W-1:0] pen_y_reg;
    logic                    box_valid_reg;
    gpl_box_t                box_reg;

    // The result register; the box fields come straight from the box state, which
    // only changes when a new result is loaded.
    logic                    out_valid_reg;
    logic signed [OUT_W-1:0] pos_x_reg;
    logic signed [OUT_W-1:0] pos_y_reg;

    logic                    s2_ready;
    logic                    s1_fire;
    logic                    in_accept;
    logic                    place_accept;
    logic                    load_accept;

    gpl_metrics_t            wr_metrics;
    gpl_metrics_t            rd_metrics;

    logic signed [OUT_W-1:0] pos_x_next;
    logic signed [OUT_W-1:0] pos_y_next;
    gpl_box_t                box_next;
    logic signed [PEN_W-1:0] pen_x_next;
    logic signed [PEN_W-1:0] pen_y_next;

    // The result register takes a new word when it is empty or being drained this cycle.
    // The lookup stage moves forward whenever the result register can take it, and the
    // input is held off only when the lookup stage is full and cannot move.
    assign s2_ready     = !out_valid_reg || !out_stall;
    assign s1_fire      = s1_valid_reg && s2_ready;
    assign in_stall     = s1_valid_reg && !s2_ready;
    assign in_accept    = in_valid && !in_stall;
    assign place_accept = in_accept && (req_type == REQ_PLACE);
    assign load_accept  = in_accept && (req_type == REQ_LOAD);

    assign wr_metrics.advance   = advance_in;
    assign wr_metrics.bearing_x = bearing_x_in;
    assign wr_metrics.bearing_y = bearing_y_in;
    assign wr_metrics.width     = glyph_width_in;
    assign wr_metrics.height    = glyph_height_in;

    // A load writes at its own acceptance edge and a place reads at its own, so a place
    // right behind a load of the same code already sees the new metrics.
    gpl_metric_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (load_accept),
        .rd_en   (place_accept),
        .code    (char_code),
        .wr_data (wr_metrics),
        .rd_data (rd_metrics)
    );

    gpl_place_calc u_calc (
        .pen_x       (pen_x_reg),
        .pen_y       (pen_y_reg),
        .box_valid   (box_valid_reg),
        .box         (box_reg),
        .metrics     (rd_metrics),
        .first       (s1_first_reg),
        .newline     (s1_newline_reg),
        .line_height (line_height_reg),
        .pos_x       (pos_x_next),
        .pos_y       (pos_y_next),
        .box_next    (box_next),
        .pen_x_next  (pen_x_next),
        .pen_y_next  (pen_y_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_height_reg <= LINE_HEIGHT_RST;
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            pen_x_reg       <= '0;
            pen_y_reg       <= '0;
            box_valid_reg   <= 1'b0;
            box_reg         <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                line_height_reg <= cfg_data;
            end

            if (place_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
                pen_x_reg     <= pen_x_next;
                pen_y_reg     <= pen_y_next;
                box_valid_reg <= 1'b1;
                box_reg       <= box_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers of the two stages.
    always_ff @(posedge clk)
    begin
        if (place_accept)
        begin
            s1_first_reg   <= first_of_string;
            s1_newline_reg <= (char_code == NEWLINE_CODE);
        end
        if (s1_fire)
        begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign box_min_x = box_reg.min_x;
    assign box_max_x = box_reg.max_x;
    assign box_min_y = box_reg.min_y;
    assign box_max_y = box_reg.max_y;

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the glyph pen layout block with running bounding box.
`timescale 1ns / 100ps

module tb_top;
    import gpl_pkg::*;

    // One word as it crosses the input channel.
    typedef struct {
        logic                       req;
        logic [CODE_W-1:0]          code;
        logic                       first;
        logic signed [METRIC_W-1:0] adv;
        logic signed [METRIC_W-1:0] bx;
        logic signed [METRIC_W-1:0] by;
        logic [SIZE_W-1:0]          wid;
        logic [SIZE_W-1:0]          hgt;
    } text_word_t;

    // One placed glyph as it leaves the output channel.
    typedef struct {
        logic signed [OUT_W-1:0] pos_x;
        logic signed [OUT_W-1:0] pos_y;
        gpl_box_t                box;
    } glyph_result_t;

    localparam logic signed [METRIC_W-1:0] MET_MAX  = 16'sh7FFF;
    localparam logic signed [METRIC_W-1:0] MET_MIN  = 16'sh8000;
    localparam logic [SIZE_W-1:0]          SIZE_MAX = 15'h7FFF;

    // Character codes used by the directed part and the long pen runs.
    localparam logic [CODE_W-1:0] CH_ZERO     = 8'd0;
    localparam logic [CODE_W-1:0] CH_TOP      = 8'd255;
    localparam logic [CODE_W-1:0] CH_A        = 8'd65;
    localparam logic [CODE_W-1:0] CH_B        = 8'd66;
    localparam logic [CODE_W-1:0] CH_UNLOADED = 8'd200;
    localparam logic [CODE_W-1:0] CH_SPARE    = 8'd201;
    localparam logic [CODE_W-1:0] CH_WIDE     = 8'd87;
    localparam logic [CODE_W-1:0] CH_BACK     = 8'd8;

    localparam int IDLE_PCT      = 37;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 6;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_write = 1'b0;
    logic [LH_W-1:0]            cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic                       req_type = 1'b0;
    logic [CODE_W-1:0]          char_code = '0;
    logic                       first_of_string = 1'b0;
    logic signed [METRIC_W-1:0] advance_in = '0;
    logic signed [METRIC_W-1:0] bearing_x_in = '0;
    logic signed [METRIC_W-1:0] bearing_y_in = '0;
    logic [SIZE_W-1:0]          glyph_width_in = '0;
    logic [SIZE_W-1:0]          glyph_height_in = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [OUT_W-1:0]    pos_x;
    logic signed [OUT_W-1:0]    pos_y;
    logic signed [OUT_W-1:0]    box_min_x;
    logic signed [OUT_W-1:0]    box_max_x;
    logic signed [OUT_W-1:0]    box_min_y;
    logic signed [OUT_W-1:0]    box_max_y;

    glyph_pen_layout_with_bounds uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .req_type        (req_type),
        .char_code       (char_code),
        .first_of_string (first_of_string),
        .advance_in      (advance_in),
        .bearing_x_in    (bearing_x_in),
        .bearing_y_in    (bearing_y_in),
        .glyph_width_in  (glyph_width_in),
        .glyph_height_in (glyph_height_in),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .pos_x           (pos_x),
        .pos_y           (pos_y),
        .box_min_x       (box_min_x),
        .box_max_x       (box_max_x),
        .box_min_y       (box_min_y),
        .box_max_y       (box_max_y)
    );

    always #6 clk = ~clk;

    // Words waiting to be driven, and glyphs whose results have not come back yet.
    text_word_t    pending_words[$];
    glyph_result_t expected_glyphs[$];
    logic [CODE_W-1:0] loaded_codes[$];

    // Our own copy of the layout state: metrics per character, pen in whole pixels,
    // the running box with its valid flag, and the line height register.
    gpl_metrics_t            metrics_table[TABLE_ENTRIES_DEF];
    logic signed [PEN_W-1:0] pen_x;
    logic signed [PEN_W-1:0] pen_y;
    gpl_box_t                run_box;
    logic                    box_live;
    logic [LH_W-1:0]         line_height;

    int         error_count;
    int         idle_cycles;
    bit         steady_run;
    text_word_t word_on_bus;
    text_word_t next_word;
    glyph_result_t got_glyph;
    glyph_result_t want_glyph;

    // Idling on either side is rolled per cycle; a steady run switches it off
    // so that one long stretch goes through at full rate.
    function automatic bit take_break();
        return !steady_run && ($urandom_range(99) < IDLE_PCT);
    endfunction

    // Saturate to a signed field of the given width.
    function automatic longint clamp_signed(longint v, int bits);
        longint lo;
        longint hi;
        lo = -(longint'(1) <<< (bits - 1));
        hi = -lo - 1;
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Place one character: origin from pen plus bearings, box grown by the
    // glyph extent truncated to whole pixels, then the pen moves on.
    function automatic void place_glyph(text_word_t w);
        gpl_metrics_t  m;
        glyph_result_t r;
        longint        adv;
        longint        bx;
        longint        by;
        longint        px;
        longint        py;
        longint        hx;
        longint        hy;
        if (w.first)
        begin
            pen_x    = '0;
            pen_y    = '0;
            box_live = 1'b0;
        end
        m   = (int'(w.code) < TABLE_ENTRIES_DEF) ? metrics_table[w.code] : '0;
        adv = $signed(m.advance);
        bx  = $signed(m.bearing_x);
        by  = $signed(m.bearing_y);
        px  = clamp_signed(longint'(pen_x) * 64 + bx, OUT_W);
        py  = clamp_signed(longint'(pen_y) * 64 - by, OUT_W);
        hx  = clamp_signed(px + (longint'(m.width) / 64) * 64, OUT_W);
        hy  = clamp_signed(py + (longint'(m.height) / 64) * 64, OUT_W);
        if (!box_live)
        begin
            // An empty box takes the whole extent of this glyph.
            run_box.min_x = OUT_W'(px);
            run_box.max_x = OUT_W'(hx);
            run_box.min_y = OUT_W'(py);
            run_box.max_y = OUT_W'(hy);
            box_live      = 1'b1;
        end
        else
        begin
            if (px < run_box.min_x) run_box.min_x = OUT_W'(px);
            if (hx > run_box.max_x) run_box.max_x = OUT_W'(hx);
            if (py < run_box.min_y) run_box.min_y = OUT_W'(py);
            if (hy > run_box.max_y) run_box.max_y = OUT_W'(hy);
        end
        if (w.code == NEWLINE_CODE)
        begin
            pen_x = '0;
            pen_y = PEN_W'(clamp_signed(longint'(pen_y) + longint'(line_height) / 64, PEN_W));
        end
        // Division on signed operands truncates toward zero, as the advance needs.
        pen_x = PEN_W'(clamp_signed(longint'(pen_x) + adv / 64, PEN_W));
        r.pos_x = OUT_W'(px);
        r.pos_y = OUT_W'(py);
        r.box   = run_box;
        expected_glyphs.push_back(r);
    endfunction

    // Apply one accepted word to the layout state.
    function automatic void apply_word(text_word_t w);
        if (w.req == REQ_LOAD)
        begin
            // A flag on a load word is ignored, and so is a code past the table.
            if (int'(w.code) < TABLE_ENTRIES_DEF)
            begin
                metrics_table[w.code].advance   = w.adv;
                metrics_table[w.code].bearing_x = w.bx;
                metrics_table[w.code].bearing_y = w.by;
                metrics_table[w.code].width     = w.wid;
                metrics_table[w.code].height    = w.hgt;
            end
        end
        else
            place_glyph(w);
    endfunction

    function automatic text_word_t random_word();
        text_word_t w;
        w.req   = 1'($urandom_range(1));
        w.code  = CODE_W'($urandom);
        w.first = 1'($urandom_range(1));
        w.adv   = METRIC_W'($urandom);
        w.bx    = METRIC_W'($urandom);
        w.by    = METRIC_W'($urandom);
        w.wid   = SIZE_W'($urandom);
        w.hgt   = SIZE_W'($urandom);
        return w;
    endfunction

    task automatic push_load(logic [CODE_W-1:0] code, logic signed [METRIC_W-1:0] adv,
                             logic signed [METRIC_W-1:0] bx, logic signed [METRIC_W-1:0] by,
                             logic [SIZE_W-1:0] wid, logic [SIZE_W-1:0] hgt, logic first);
        text_word_t w;
        w.req   = REQ_LOAD;
        w.code  = code;
        w.first = first;
        w.adv   = adv;
        w.bx    = bx;
        w.by    = by;
        w.wid   = wid;
        w.hgt   = hgt;
        pending_words.push_back(w);
    endtask

    task automatic push_place(logic [CODE_W-1:0] code, logic first);
        text_word_t w;
        w       = random_word();
        w.req   = REQ_PLACE;
        w.code  = code;
        w.first = first;
        pending_words.push_back(w);
    endtask

    // A string of one character, with a given share of newlines mixed in.
    task automatic push_run(logic [CODE_W-1:0] code, int count, int newline_pct);
        for (int k = 0; k < count; k++)
            push_place(($urandom_range(99) < newline_pct) ? NEWLINE_CODE : code, k == 0);
    endtask

    // Mostly well-formed text: metric loads followed by strings that start with
    // the first-of-string flag and reuse loaded codes and newlines. The rest is
    // fully random noise and strings that start without the flag.
    task automatic push_random_text(int n_words);
        text_word_t w;
        int         made;
        int         len;
        int         roll;
        made = 0;
        while (made < n_words)
        begin
            roll = $urandom_range(99);
            if (roll < 12)
            begin
                pending_words.push_back(random_word());
                made++;
            end
            else if (roll < 32)
            begin
                w     = random_word();
                w.req = REQ_LOAD;
                if ($urandom_range(7) == 0)
                    w.code = NEWLINE_CODE;
                loaded_codes.push_back(w.code);
                pending_words.push_back(w);
                made++;
            end
            else
            begin
                len = $urandom_range(1, 10);
                for (int k = 0; k < len; k++)
                begin
                    w       = random_word();
                    w.req   = REQ_PLACE;
                    w.first = (k == 0) ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0);
                    roll    = $urandom_range(9);
                    if (roll < 2)
                        w.code = NEWLINE_CODE;
                    else if (roll < 8 && loaded_codes.size() != 0)
                        w.code = loaded_codes[$urandom_range(loaded_codes.size() - 1)];
                    pending_words.push_back(w);
                end
                made += len;
            end
        end
    endtask

    // Wait until every word is sent and every result is back, then give the
    // block time to finish table writes, which return nothing.
    task automatic wait_idle();
        for (int k = 0; k < DRAIN_LIMIT; k++)
        begin
            if (pending_words.size() == 0 && !in_valid && expected_glyphs.size() == 0)
                break;
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // The line height is only written while the block is idle, so our copy can
    // change at the same moment.
    task automatic set_line_height(logic [LH_W-1:0] value);
        @(posedge clk);
        cfg_write   <= 1'b1;
        cfg_data    <= value;
        line_height  = value;
        @(posedge clk);
        cfg_write   <= 1'b0;
    endtask

    task automatic check_field(string name, longint want, longint got);
        if (want != got)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    // Input driver. A word stays on the bus until it is accepted; at the edge
    // that accepts it our state is advanced, and then the next word is put up
    // or the bus goes idle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                apply_word(word_on_bus);
            if (!in_valid || !in_stall)
            begin
                if (pending_words.size() != 0 && !take_break())
                begin
                    next_word        = pending_words.pop_front();
                    word_on_bus      = next_word;
                    in_valid        <= 1'b1;
                    req_type        <= next_word.req;
                    char_code       <= next_word.code;
                    first_of_string <= next_word.first;
                    advance_in      <= next_word.adv;
                    bearing_x_in    <= next_word.bx;
                    bearing_y_in    <= next_word.by;
                    glyph_width_in  <= next_word.wid;
                    glyph_height_in <= next_word.hgt;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Output monitor. Every accepted result is matched against the oldest
    // glyph still waiting; the stall is rolled fresh each cycle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got_glyph.pos_x     = pos_x;
                got_glyph.pos_y     = pos_y;
                got_glyph.box.min_x = box_min_x;
                got_glyph.box.max_x = box_max_x;
                got_glyph.box.min_y = box_min_y;
                got_glyph.box.max_y = box_max_y;
                if (expected_glyphs.size() == 0)
                begin
                    error_count++;
                    $display("%0t: result with no glyph waiting, expected none actual x %0d y %0d",
                             $time, got_glyph.pos_x, got_glyph.pos_y);
                end
                else
                begin
                    want_glyph = expected_glyphs.pop_front();
                    check_field("pos_x", want_glyph.pos_x, got_glyph.pos_x);
                    check_field("pos_y", want_glyph.pos_y, got_glyph.pos_y);
                    check_field("box_min_x", want_glyph.box.min_x, got_glyph.box.min_x);
                    check_field("box_max_x", want_glyph.box.max_x, got_glyph.box.max_x);
                    check_field("box_min_y", want_glyph.box.min_y, got_glyph.box.min_y);
                    check_field("box_max_y", want_glyph.box.max_y, got_glyph.box.max_y);
                end
            end
            out_stall <= take_break();
        end
    end

    // Watchdog: a hung channel shows up as a long run of cycles with no word
    // accepted on either side.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        error_count = 0;
        idle_cycles = 0;
        steady_run  = 1'b0;
        pen_x       = '0;
        pen_y       = '0;
        run_box     = '0;
        box_live    = 1'b0;
        line_height = LINE_HEIGHT_RST;
        for (int i = 0; i < TABLE_ENTRIES_DEF; i++)
            metrics_table[i] = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset line height. It opens with a glyph whose
        // metrics were never loaded, placed into the empty box left by reset.
        push_place(CH_UNLOADED, 1'b0);
        push_load(CH_ZERO, MET_MAX, MET_MIN, MET_MAX, SIZE_MAX, '0, 1'b0);
        // A load carrying the first-of-string flag must not touch the pen.
        push_load(CH_TOP, MET_MIN, MET_MAX, MET_MIN, '0, SIZE_MAX, 1'b1);
        push_load(NEWLINE_CODE, 16'sd192, 16'sd5, 16'sd100, 15'd640, 15'd1280, 1'b0);
        // Sizes just under a pixel truncate to nothing; small advances truncate toward zero.
        push_load(CH_A, 16'sd127, -16'sd1, 16'sd63, 15'd63, 15'd64, 1'b0);
        push_load(CH_B, -16'sd65, 16'sd0, -16'sd1, 15'd64, 15'd63, 1'b0);
        push_place(CH_A, 1'b1);
        push_place(CH_ZERO, 1'b0);
        push_place(CH_TOP, 1'b0);
        push_place(NEWLINE_CODE, 1'b0);
        push_place(CH_B, 1'b0);
        push_place(CH_B, 1'b0);
        push_place(NEWLINE_CODE, 1'b0);
        push_place(CH_TOP, 1'b1);
        push_place(CH_SPARE, 1'b0);
        push_load(CH_A, -16'sd1, 16'sd1, -16'sd1, SIZE_MAX, SIZE_MAX, 1'b0);
        push_place(CH_A, 1'b0);
        push_place(NEWLINE_CODE, 1'b1);
        push_place(CH_ZERO, 1'b0);
        wait_idle();

        // Zero line height: newlines return the pen without moving down.
        set_line_height('0);
        push_random_text(30);
        wait_idle();

        // Greatest line height: a run of mostly newlines moves pen y down in big steps.
        set_line_height('1);
        push_load(NEWLINE_CODE, MET_MAX, METRIC_W'($urandom), MET_MIN, SIZE_MAX, SIZE_MAX, 1'b0);
        push_load(CH_WIDE, MET_MAX, MET_MAX, MET_MIN, SIZE_MAX, SIZE_MAX, 1'b0);
        push_run(CH_WIDE, 30, 70);
        push_random_text(20);
        wait_idle();

        // Random line height. The widest advance drives pen x and the x outputs
        // to their upper limits at full rate, then the most negative advance
        // walks the pen to the left with idling back on.
        set_line_height(LH_W'($urandom));
        push_load(CH_WIDE, MET_MAX, MET_MAX, METRIC_W'($urandom), SIZE_MAX, SIZE_MAX, 1'b0);
        push_load(CH_BACK, MET_MIN, MET_MIN, METRIC_W'($urandom), SIZE_W'($urandom), '0, 1'b0);
        wait_idle();
        steady_run = 1'b1;
        push_run(CH_WIDE, 262, 0);
        wait_idle();
        steady_run = 1'b0;
        push_run(CH_BACK, 20, 10);
        wait_idle();

        // Just under one pixel of line height truncates to nothing.
        set_line_height(16'd63);
        push_random_text(15);
        wait_idle();

        set_line_height(16'd64);
        push_random_text(15);
        wait_idle();

        if (expected_glyphs.size() != 0)
        begin
            error_count++;
            $display("%0t: %0d glyph results never arrived, expected 0 actual %0d",
                     $time, expected_glyphs.size(), expected_glyphs.size());
        end

        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
